// ===== src/rif_pkg.sv =====
package rif_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_GRID_DEF      = 16;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int PIXEL_BITS_DEF    = 8;

  // Configuration port.
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_REG_W  = 13;
  localparam int GRID_REG_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 2'd2;

  localparam int WIDTH_RESET  = 64;
  localparam int HEIGHT_RESET = 64;
  localparam int GRID_RESET   = 8;

  // Result width; the full-scale value is 2**FEAT_W - 1.
  localparam int FEAT_W    = 8;
  localparam int ROTATIONS = 4;
  localparam int ROT_W     = $clog2(ROTATIONS);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ADV,
    OP_CELL_RD,
    OP_CELL_WR,
    OP_FOLD_RD,
    OP_FOLD_ADD,
    OP_FOLD_ST,
    OP_NORM_INIT,
    OP_NORM_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic adv_need;
    logic more_cell;
    logic last_pix;
    logic rot_last;
    logic fold_done;
    logic div_last;
    logic out_free;
    logic norm_last;
  } stat_t;

endpackage

// ===== src/rif_ctrl.sv =====
module rif_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rif_pkg::stat_t stat,
  output rif_pkg::op_t   op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_CRD,
    ST_CWR,
    ST_FRD,
    ST_FADD,
    ST_FST,
    ST_NRD,
    ST_NINI,
    ST_NDIV,
    ST_NEMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = rif_pkg::OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = rif_pkg::OP_ACCEPT;
          state_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        op = rif_pkg::OP_ADV;
        if (!stat.adv_need) state_nxt = ST_CRD;
      end
      ST_CRD: begin
        op        = rif_pkg::OP_CELL_RD;
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        op = rif_pkg::OP_CELL_WR;
        if (stat.more_cell)     state_nxt = ST_CRD;
        else if (stat.last_pix) state_nxt = ST_FRD;
        else                    state_nxt = ST_IDLE;
      end
      ST_FRD: begin
        op        = rif_pkg::OP_FOLD_RD;
        state_nxt = ST_FADD;
      end
      ST_FADD: begin
        op        = rif_pkg::OP_FOLD_ADD;
        state_nxt = stat.rot_last ? ST_FST : ST_FRD;
      end
      ST_FST: begin
        op        = rif_pkg::OP_FOLD_ST;
        state_nxt = stat.fold_done ? ST_NRD : ST_FRD;
      end
      ST_NRD: begin
        state_nxt = ST_NINI;
      end
      ST_NINI: begin
        op        = rif_pkg::OP_NORM_INIT;
        state_nxt = ST_NDIV;
      end
      ST_NDIV: begin
        op = rif_pkg::OP_NORM_STEP;
        if (stat.div_last) state_nxt = ST_NEMIT;
      end
      ST_NEMIT: begin
        if (stat.out_free) begin
          op        = rif_pkg::OP_EMIT;
          state_nxt = stat.norm_last ? ST_IDLE : ST_NRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/rif_dp.sv =====
module rif_dp #(
  parameter int MAX_GRID      = rif_pkg::MAX_GRID_DEF,
  parameter int MAX_DIMENSION = rif_pkg::MAX_DIMENSION_DEF,
  parameter int PIXEL_BITS    = rif_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rif_pkg::op_t                   op,
  output rif_pkg::stat_t                 stat,
  input  logic [PIXEL_BITS-1:0]          in_pixel_value,
  input  logic                           cfg_we,
  input  logic [rif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rif_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rif_pkg::FEAT_W-1:0]     out_feature_value,
  output logic                           out_feature_last
);

  localparam int DW     = $clog2(MAX_DIMENSION + 1);
  localparam int PW     = $clog2(MAX_DIMENSION);
  localparam int GW     = $clog2(MAX_GRID + 1);
  localparam int SW     = $clog2(MAX_DIMENSION * (MAX_GRID + 1) + 1);
  localparam int CDEPTH = MAX_GRID * MAX_GRID;
  localparam int AW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int FDEPTH = (CDEPTH + 3) / 4;
  localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int FCW    = $clog2(FDEPTH + 1);
  localparam int ACC_W  = PIXEL_BITS + 2 * PW;
  localparam int FOLD_W = ACC_W + 2;
  localparam int OXY_W  = 2 * GW;
  localparam int WT_W   = PIXEL_BITS + OXY_W;
  localparam int FW     = rif_pkg::FEAT_W;
  localparam int REM_W  = FOLD_W + FW;
  localparam int DCW    = $clog2(FW);

  // Configuration registers and their clamped values.
  logic [rif_pkg::DIM_REG_W-1:0]  width_raw_r, height_raw_r;
  logic [rif_pkg::GRID_REG_W-1:0] grid_raw_r;
  logic [DW-1:0] w_c, h_c;
  logic [GW-1:0] g_c, gm1;
  logic [SW-1:0] w_s, h_s, g_s;

  // Pixel walk.
  logic [PIXEL_BITS-1:0] pix_r;
  logic [PW-1:0] x_r, y_r;
  logic [SW-1:0] xs_r, ys_r, bx0_r, by0_r, bx_r, by_r;
  logic [GW-1:0] cx0_r, cy0_r, cx_r, cy_r;
  logic [AW-1:0] rb0_r, rb_r, addr_r;
  logic [OXY_W-1:0] oxy_r;
  logic [CDEPTH-1:0] vld_r;
  logic rd_vld_r;
  logic [ACC_W-1:0] rd_data_r;

  // Folding and normalization.
  logic [GW-1:0] fr_r, fc_r;
  logic [rif_pkg::ROT_W-1:0] k_r;
  logic [FCW-1:0] n_r, m_r;
  logic [FOLD_W-1:0] fsum_r, min_r, max_r, fold_rd_r;
  logic [REM_W-1:0] rem_r, dsh_r;
  logic [FW-1:0] q_r;
  logic [DCW-1:0] dcnt_r;

  logic out_valid_r, out_last_r;
  logic [FW-1:0] out_value_r;

  logic [SW-1:0] xe, ye, bx0_end, by0_end, bx_end, by_end;
  logic [SW-1:0] ox_full, oy_full;
  logic adv_x, adv_y, more_cx, more_cy, last_pix, x_wrap;
  logic [AW-1:0] cell_raddr, fold_addr;
  logic [GW-1:0] f_row, f_col;
  logic [ACC_W-1:0] cell_val, cell_wdata;
  logic [WT_W-1:0] weight;
  logic fnext_ok, fold_done, out_free, range_zero;
  logic [GW:0] half_g;
  logic [FOLD_W-1:0] diff, drange;
  logic cfg_restart, restart;

  logic [ACC_W-1:0]  cell_mem [CDEPTH];
  logic [FOLD_W-1:0] fold_mem [FDEPTH];

  always_comb begin
    if (width_raw_r == '0)                      w_c = DW'(1);
    else if (32'(width_raw_r) > MAX_DIMENSION)  w_c = DW'(MAX_DIMENSION);
    else                                        w_c = DW'(width_raw_r);
    if (height_raw_r == '0)                     h_c = DW'(1);
    else if (32'(height_raw_r) > MAX_DIMENSION) h_c = DW'(MAX_DIMENSION);
    else                                        h_c = DW'(height_raw_r);
    if (grid_raw_r == '0)                       g_c = GW'(1);
    else if (32'(grid_raw_r) > MAX_GRID)        g_c = GW'(MAX_GRID);
    else                                        g_c = GW'(grid_raw_r);
  end

  assign w_s = SW'(w_c);
  assign h_s = SW'(h_c);
  assign g_s = SW'(g_c);
  assign gm1 = g_c - GW'(1);

  // A pixel covers [xs, xe) and a cell [bx, bx + w) in scaled coordinates.
  assign xe      = xs_r + g_s;
  assign ye      = ys_r + g_s;
  assign bx0_end = bx0_r + w_s;
  assign by0_end = by0_r + h_s;
  assign bx_end  = bx_r + w_s;
  assign by_end  = by_r + h_s;
  assign adv_x   = (bx0_end <= xs_r);
  assign adv_y   = (by0_end <= ys_r);
  assign ox_full = ((xe < bx_end) ? xe : bx_end) - ((xs_r > bx_r) ? xs_r : bx_r);
  assign oy_full = ((ye < by_end) ? ye : by_end) - ((ys_r > by_r) ? ys_r : by_r);
  assign more_cx = (GW'(cx_r + GW'(1)) < g_c) && (bx_end < xe);
  assign more_cy = (GW'(cy_r + GW'(1)) < g_c) && (by_end < ye);
  assign last_pix = (DW'(x_r) == w_c - DW'(1)) && (DW'(y_r) == h_c - DW'(1));
  assign x_wrap   = ((DW'(x_r) + DW'(1)) >= w_c);

  // The four rotations of cell (r, c) on a g by g grid.
  always_comb begin
    case (k_r)
      2'd0: begin
        f_row = fr_r;        f_col = fc_r;
      end
      2'd1: begin
        f_row = gm1 - fc_r;  f_col = fr_r;
      end
      2'd2: begin
        f_row = gm1 - fr_r;  f_col = gm1 - fc_r;
      end
      default: begin
        f_row = fc_r;        f_col = gm1 - fr_r;
      end
    endcase
  end

  assign fold_addr  = AW'(OXY_W'(f_row) * OXY_W'(g_c) + OXY_W'(f_col));
  assign cell_raddr = (op == rif_pkg::OP_FOLD_RD) ? fold_addr : AW'(rb_r + AW'(cx_r));
  assign cell_val   = rd_vld_r ? rd_data_r : '0;
  assign weight     = WT_W'(pix_r) * WT_W'(oxy_r);
  assign cell_wdata = cell_val + ACC_W'(weight);

  assign fnext_ok  = ((GW + 1)'(fc_r) + (GW + 1)'(fr_r) + (GW + 1)'(2)) < (GW + 1)'(g_c);
  assign half_g    = ((GW + 1)'(g_c) + (GW + 1)'(1)) >> 1;
  assign fold_done = !fnext_ok && (((GW + 1)'(fr_r) + (GW + 1)'(1)) == half_g);

  assign diff       = fold_rd_r - min_r;
  assign drange     = max_r - min_r;
  assign range_zero = (max_r == min_r);
  assign out_free   = !out_valid_r || !out_stall;

  assign cfg_restart = cfg_we && ((cfg_index == rif_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index == rif_pkg::REG_IMAGE_HEIGHT) ||
                                  (cfg_index == rif_pkg::REG_GRID_SIZE));
  assign restart = cfg_restart || ((op == rif_pkg::OP_FOLD_ST) && fold_done);

  assign stat.adv_need  = adv_x || adv_y;
  assign stat.more_cell = more_cx || more_cy;
  assign stat.last_pix  = last_pix;
  assign stat.rot_last  = (k_r == rif_pkg::ROT_W'(rif_pkg::ROTATIONS - 1));
  assign stat.fold_done = fold_done;
  assign stat.div_last  = (dcnt_r == DCW'(FW - 1));
  assign stat.out_free  = out_free;
  assign stat.norm_last = ((m_r + FCW'(1)) == n_r);

  assign out_valid         = out_valid_r;
  assign out_feature_value = out_value_r;
  assign out_feature_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (op == rif_pkg::OP_CELL_WR) cell_mem[addr_r] <= cell_wdata;
    rd_data_r <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (op == rif_pkg::OP_FOLD_ST) fold_mem[n_r[FAW-1:0]] <= fsum_r;
    fold_rd_r <= fold_mem[m_r[FAW-1:0]];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[cell_raddr];
    case (op)
      rif_pkg::OP_ACCEPT: pix_r <= in_pixel_value;
      rif_pkg::OP_CELL_RD: begin
        addr_r <= cell_raddr;
        oxy_r  <= OXY_W'(GW'(ox_full)) * OXY_W'(GW'(oy_full));
      end
      rif_pkg::OP_FOLD_ADD: begin
        fsum_r <= (k_r == '0) ? FOLD_W'(cell_val) : fsum_r + FOLD_W'(cell_val);
      end
      rif_pkg::OP_NORM_INIT: begin
        // diff * 255 over range, one quotient bit per step.
        rem_r <= (REM_W'(diff) << FW) - REM_W'(diff);
        dsh_r <= REM_W'(drange) << (FW - 1);
        q_r   <= '0;
      end
      rif_pkg::OP_NORM_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[FW-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[FW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      rif_pkg::OP_EMIT: begin
        if (out_free) begin
          out_value_r <= range_zero ? '0 : q_r;
          out_last_r  <= stat.norm_last;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= rif_pkg::DIM_REG_W'(rif_pkg::WIDTH_RESET);
      height_raw_r <= rif_pkg::DIM_REG_W'(rif_pkg::HEIGHT_RESET);
      grid_raw_r   <= rif_pkg::GRID_REG_W'(rif_pkg::GRID_RESET);
      x_r <= '0;  y_r <= '0;  xs_r <= '0;  ys_r <= '0;
      cx0_r <= '0;  bx0_r <= '0;  cy0_r <= '0;  by0_r <= '0;  rb0_r <= '0;
      cx_r <= '0;  bx_r <= '0;  cy_r <= '0;  by_r <= '0;  rb_r <= '0;
      vld_r <= '0;
      fr_r <= '0;  fc_r <= '0;  k_r <= '0;  n_r <= '0;  m_r <= '0;
      min_r <= '0;  max_r <= '0;
      dcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // An emit into a free slot sets the valid flag below.
      if (out_valid_r && !out_stall && (op != rif_pkg::OP_EMIT)) out_valid_r <= 1'b0;

      case (op)
        rif_pkg::OP_ADV: begin
          if (adv_x) begin
            cx0_r <= cx0_r + GW'(1);
            bx0_r <= bx0_end;
          end else if (adv_y) begin
            cy0_r <= cy0_r + GW'(1);
            by0_r <= by0_end;
            rb0_r <= rb0_r + AW'(g_c);
          end else begin
            cx_r <= cx0_r;  bx_r <= bx0_r;
            cy_r <= cy0_r;  by_r <= by0_r;  rb_r <= rb0_r;
          end
        end
        rif_pkg::OP_CELL_WR: begin
          vld_r[addr_r] <= 1'b1;
          if (more_cx) begin
            cx_r <= cx_r + GW'(1);
            bx_r <= bx_end;
          end else if (more_cy) begin
            cy_r <= cy_r + GW'(1);
            by_r <= by_end;
            rb_r <= rb_r + AW'(g_c);
            cx_r <= cx0_r;
            bx_r <= bx0_r;
          end else if (last_pix) begin
            fr_r <= '0;  fc_r <= '0;  k_r <= '0;  n_r <= '0;
          end else if (x_wrap) begin
            x_r   <= '0;
            xs_r  <= '0;
            cx0_r <= '0;
            bx0_r <= '0;
            y_r   <= y_r + PW'(1);
            ys_r  <= ys_r + g_s;
          end else begin
            x_r  <= x_r + PW'(1);
            xs_r <= xs_r + g_s;
          end
        end
        rif_pkg::OP_FOLD_ADD: begin
          k_r <= k_r + rif_pkg::ROT_W'(1);
        end
        rif_pkg::OP_FOLD_ST: begin
          if (n_r == '0) begin
            min_r <= fsum_r;
            max_r <= fsum_r;
          end else begin
            if (fsum_r < min_r) min_r <= fsum_r;
            if (fsum_r > max_r) max_r <= fsum_r;
          end
          n_r <= n_r + FCW'(1);
          if (fnext_ok) begin
            fc_r <= fc_r + GW'(1);
          end else begin
            fr_r <= fr_r + GW'(1);
            fc_r <= fr_r + GW'(1);
          end
          if (fold_done) m_r <= '0;
        end
        rif_pkg::OP_NORM_INIT: dcnt_r <= '0;
        rif_pkg::OP_NORM_STEP: dcnt_r <= dcnt_r + DCW'(1);
        rif_pkg::OP_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            m_r <= m_r + FCW'(1);
          end
        end
        default: begin
        end
      endcase

      if (cfg_we) begin
        case (cfg_index)
          rif_pkg::REG_IMAGE_WIDTH:  width_raw_r  <= cfg_wdata;
          rif_pkg::REG_IMAGE_HEIGHT: height_raw_r <= cfg_wdata;
          rif_pkg::REG_GRID_SIZE:    grid_raw_r   <= cfg_wdata[rif_pkg::GRID_REG_W-1:0];
          default: begin
          end
        endcase
      end

      if (restart) begin
        x_r <= '0;  y_r <= '0;  xs_r <= '0;  ys_r <= '0;
        cx0_r <= '0;  bx0_r <= '0;  cy0_r <= '0;  by0_r <= '0;  rb0_r <= '0;
        vld_r <= '0;
      end
    end
  end

endmodule

// ===== src/rotation_invariant_image_fingerprint.sv =====
// Port group   Direction  Handshake            Payload
// in_          input      in_valid / in_stall  in_pixel_value
// out_         output     out_valid / out_stall out_feature_value, out_feature_last
// cfg_         input      cfg_we               cfg_index, cfg_wdata
//
// A pixel is accepted, then stepped to its first cell once per cell boundary
// crossed, and then read, added and written back for each cell it touches.
// After the last pixel, each orbit cell is folded (a read and an add per rotation,
// then a store) and each result is made in turn (read, setup, 8 divider steps, load),
// waiting while the output is stalled. An offered result does not block pixels.
// Reset is synchronous and needs no clearing pass: cell sums carry valid bits.
// Pixels are taken only while idle; a result still waiting to load blocks them.
module rotation_invariant_image_fingerprint #(
  parameter int MAX_GRID      = rif_pkg::MAX_GRID_DEF,
  parameter int MAX_DIMENSION = rif_pkg::MAX_DIMENSION_DEF,
  parameter int PIXEL_BITS    = rif_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PIXEL_BITS-1:0]         in_pixel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rif_pkg::FEAT_W-1:0]    out_feature_value,
  output logic                          out_feature_last,
  input  logic                          cfg_we,
  input  logic [rif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rif_pkg::CFG_W-1:0]     cfg_wdata
);

  rif_pkg::op_t   op;
  rif_pkg::stat_t stat;

  rif_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  rif_dp #(
    .MAX_GRID      (MAX_GRID),
    .MAX_DIMENSION (MAX_DIMENSION),
    .PIXEL_BITS    (PIXEL_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .in_pixel_value    (in_pixel_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_feature_value (out_feature_value),
    .out_feature_last  (out_feature_last)
  );

endmodule

// ===== src/rif_checker.sv =====
module rif_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rif_pkg::FEAT_W-1:0] out_feature_value,
  input logic                       out_feature_last
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_feature_value) && $stable(out_feature_last))
    else $error("result changed while stalled");

  // The stall rises in the cycle after a pixel is accepted, for its cell work.
  a_busy_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("pixel accepted back to back");

  // Reset leaves the block ready for pixels with nothing to deliver.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind rotation_invariant_image_fingerprint rif_checker u_rif_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_feature_value (out_feature_value),
  .out_feature_last  (out_feature_last)
);
